// ===== hdl/tfc_pkg.sv =====
`default_nettype none
package tfc_pkg;
  localparam int MAX_FILTER_DEF = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_XX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_XY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_XOFF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_YX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_YY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_YOFF = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DIV = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE = 3'd7;

  typedef struct packed {
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic [4:0]         buttons;
  } in_item_t;

  typedef struct packed {
    logic               event_valid;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic [4:0]         event_buttons;
    logic               accepted;
  } out_item_t;

  // divider handshake
  typedef struct packed {
    logic               start;
    logic signed [65:0] num;
    logic signed [17:0] den;
  } div_req_t;
endpackage
`default_nettype wire

// ===== hdl/tfc_stream_if.sv =====
`default_nettype none
interface tfc_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/tfc_divider.sv =====
`default_nettype none
// Restoring divider, one quotient bit a cycle, truncates toward zero.
module tfc_divider (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tfc_pkg::div_req_t   req,
  output logic                     done,
  output logic signed [65:0]       quot,
  output logic                     exact
);
  localparam int NW = 66;
  logic [NW-1:0] q, rem;
  logic [17:0]   dmag;
  logic          neg, busy;
  logic [6:0]    cnt;
  logic [NW:0]   trial;

  assign trial = {rem[NW-1:0], q[NW-1]} - {{(NW-17){1'b0}}, dmag};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= 7'(NW);
      rem  <= '0;
      q    <= req.num[NW-1] ? NW'(-req.num) : NW'(req.num);
      dmag <= req.den[17] ? 18'(-req.den) : 18'(req.den);
      neg  <= req.num[NW-1] ^ req.den[17];
    end else if (busy) begin
      if (!trial[NW]) begin
        rem <= trial[NW-1:0];
        q   <= {q[NW-2:0], 1'b1};
      end else begin
        rem <= {rem[NW-2:0], q[NW-1]};
        q   <= {q[NW-2:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quot  = neg ? -$signed(q) : $signed(q);
  // no remainder left: the quotient is exact
  assign exact = (rem == '0);
endmodule
`default_nettype wire

// ===== hdl/touch_filter_and_calibrate.sv =====
`default_nettype none
// Sequence: a held sample that fills the ring makes two passes over the ring (one for
//   N of 2 or less) and four divisions in the shared divider; a release with a full
//   ring maps the raw point with two divisions; any other sample goes straight to the
//   output; a zero divisor skips the two mapping divisions.
// Throughput: one item at a time; ready returns the cycle after the result transfers.
// Reset: identity coefficients, divisor 1, size 5; count, index, last point clear.
module touch_filter_and_calibrate #(
  parameter int MAX_FILTER = tfc_pkg::MAX_FILTER_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  tfc_stream_if.sink                          in_ch,
  tfc_stream_if.source                        out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [tfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tfc_pkg::CFG_DATA_W-1:0] cfg_data
);
  localparam int IW = (MAX_FILTER > 1) ? $clog2(MAX_FILTER) : 1;
  localparam int CW = $clog2(MAX_FILTER + 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_DIST = 4'd1, S_SUM = 4'd2,
    S_AVGX = 4'd3, S_AVGY = 4'd4, S_MUL0 = 4'd5, S_MUL1 = 4'd6,
    S_DIVW = 4'd7, S_OUT = 4'd8;

  // configuration
  logic signed [31:0] cxx, cxy, cxo, cyx, cyy, cyo;
  logic signed [17:0] cdiv;
  logic [CW-1:0]      nsize;

  // sample state
  logic [31:0]   ring [MAX_FILTER];
  logic [IW-1:0] widx;
  logic [CW-1:0] scount;
  logic signed [15:0] last_x, last_y;

  // sequencer
  logic [3:0]    state;
  logic [CW-1:0] i;
  logic          release_item, axis_y;
  logic [4:0]    btn;
  logic signed [15:0] px, py;
  logic [17:0]   maxd;
  logic [CW-1:0] drop;
  logic          drop_ok;
  logic signed [20+CW:0] sumx, sumy;
  logic [CW-1:0] cnt;
  logic signed [65:0] acc;
  logic signed [15:0] resx;
  logic [31:0]   rd;

  logic signed [16:0] dx, dy;
  logic [16:0]   adx, ady;
  logic [17:0]   mdist;
  logic [CW-1:0] nclamp;

  // shared 32x16 multiplier
  logic signed [31:0] mgain;
  logic signed [15:0] mcoord;
  logic signed [47:0] prod;

  tfc_pkg::div_req_t dreq;
  logic              ddone;
  logic              dexact;
  logic              avg_issue, div_go;
  logic signed [65:0] dquot;
  logic signed [15:0] sat;
  tfc_pkg::out_item_t res;

  tfc_divider u_div (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .quot(dquot),
                     .exact(dexact));

  // clamp filter size write to 1..MAX_FILTER
  always_comb begin
    if (cfg_data[4:0] == 5'd0) nclamp = CW'(1);
    else if (32'(cfg_data[4:0]) > 32'(MAX_FILTER)) nclamp = CW'(MAX_FILTER);
    else nclamp = CW'(cfg_data[4:0]);
  end

  assign rd  = ring[i[IW-1:0]];
  assign dx  = 17'(last_x) - 17'($signed(rd[15:0]));
  assign dy  = 17'(last_y) - 17'($signed(rd[31:16]));
  assign adx = dx[16] ? 17'(-dx) : 17'(dx);
  assign ady = dy[16] ? 17'(-dy) : 17'(dy);
  assign mdist = 18'(adx) + 18'(ady);

  // first product takes the x term, second the y term
  assign mgain  = (state == S_MUL0) ? (axis_y ? cyx : cxx) : (axis_y ? cyy : cxy);
  assign mcoord = (state == S_MUL0) ? px : py;
  assign prod   = mgain * mcoord;

  assign sat = (dquot > 66'sd32767) ? 16'sh7fff :
               (dquot < -66'sd32768) ? 16'sh8000 : 16'(dquot);

  // launch an averaging division once per axis, a mapping division unless the divisor is zero
  assign avg_issue = ((state == S_AVGX) || (state == S_AVGY)) &&
                     !dreq.start && !ddone && !acc[0];
  assign div_go = avg_issue || ((state == S_MUL1) && (cdiv != 18'sd0));

  assign in_ch.ready = (state == S_IDLE) && !out_ch.valid;

  always_ff @(posedge clk) begin
    dreq.start <= !rst && div_go;
    if (rst) begin
      cxx <= 32'sd1; cxy <= '0; cxo <= '0; cyx <= '0; cyy <= 32'sd1; cyo <= '0;
      cdiv <= 18'sd1; nsize <= CW'(5 > MAX_FILTER ? MAX_FILTER : 5);
      widx <= '0; scount <= '0; last_x <= '0; last_y <= '0;
      acc <= '0;
      state <= S_IDLE; out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          tfc_pkg::REG_XX:   cxx <= cfg_data;
          tfc_pkg::REG_XY:   cxy <= cfg_data;
          tfc_pkg::REG_XOFF: cxo <= cfg_data;
          tfc_pkg::REG_YX:   cyx <= cfg_data;
          tfc_pkg::REG_YY:   cyy <= cfg_data;
          tfc_pkg::REG_YOFF: cyo <= cfg_data;
          tfc_pkg::REG_DIV:  cdiv <= cfg_data[17:0];
          tfc_pkg::REG_SIZE: begin
            nsize <= nclamp; scount <= '0; widx <= '0;
          end
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            btn <= in_ch.data.buttons;
            axis_y <= 1'b0;
            if (in_ch.data.buttons == 5'd0) begin
              // release: map raw point only if the ring was full
              release_item <= 1'b1;
              scount <= '0; widx <= '0;
              px <= in_ch.data.raw_x; py <= in_ch.data.raw_y;
              state <= (scount >= nsize) ? S_MUL0 : S_OUT;
              res <= '{event_valid: 1'b0, screen_x: 16'sd0, screen_y: 16'sd0,
                       event_buttons: 5'd0, accepted: 1'b1};
            end else begin
              release_item <= 1'b0;
              res <= '0;
              ring[widx] <= {in_ch.data.raw_y, in_ch.data.raw_x};
              widx <= (32'(widx) + 1 >= 32'(nsize)) ? '0 : widx + IW'(1);
              if (scount >= nsize - CW'(1)) begin
                scount <= nsize;
                i <= '0; maxd <= '0; drop_ok <= 1'b0;
                state <= (nsize > CW'(2)) ? S_DIST : S_SUM;
                sumx <= '0; sumy <= '0; cnt <= '0;
              end else begin
                scount <= scount + CW'(1);
                state <= S_OUT;
              end
            end
          end
        end
        S_DIST: begin
          // find first farthest sample from last sent point
          if (mdist > maxd) begin
            maxd <= mdist; drop <= i; drop_ok <= 1'b1;
          end
          if (i == nsize - CW'(1)) begin
            i <= '0; state <= S_SUM;
          end else i <= i + CW'(1);
        end
        S_SUM: begin
          if (!(drop_ok && drop == i)) begin
            sumx <= sumx + $signed(rd[15:0]);
            sumy <= sumy + $signed(rd[31:16]);
            cnt <= cnt + CW'(1);
          end
          if (i == nsize - CW'(1)) state <= S_AVGX;
          else i <= i + CW'(1);
        end
        S_AVGX, S_AVGY: begin
          // floor((2*sum+cnt)/(2*cnt)) via divider; fix up toward minus infinity
          if (avg_issue) begin
            dreq.num <= 66'(state == S_AVGX ? sumx : sumy) * 66'sd2 + 66'(cnt);
            dreq.den <= 18'(cnt) <<< 1;
            acc[0] <= 1'b1;
          end else if (ddone) begin
            acc[0] <= 1'b0;
            if (state == S_AVGX) begin
              px <= 16'(dquot - ((!dexact && dreq.num < 0) ? 66'sd1 : 66'sd0));
              state <= S_AVGY;
            end else begin
              py <= 16'(dquot - ((!dexact && dreq.num < 0) ? 66'sd1 : 66'sd0));
              state <= S_MUL0;
            end
          end
        end
        S_MUL0: begin
          acc <= 66'(prod) + 66'(axis_y ? cyo : cxo);
          state <= S_MUL1;
        end
        S_MUL1: begin
          dreq.num <= acc + 66'(prod);
          dreq.den <= cdiv;
          acc <= '0;
          state <= S_DIVW;
        end
        S_DIVW: begin
          if (cdiv == 18'sd0 || ddone) begin
            if (!axis_y) begin
              resx <= (cdiv == 18'sd0) ? 16'sd0 : sat;
              axis_y <= 1'b1;
              state <= S_MUL0;
            end else begin
              res.event_valid <= 1'b1;
              res.accepted <= 1'b1;
              res.screen_x <= resx;
              res.screen_y <= (cdiv == 18'sd0) ? 16'sd0 : sat;
              res.event_buttons <= release_item ? 5'd0 : btn;
              last_x <= resx;
              last_y <= (cdiv == 18'sd0) ? 16'sd0 : sat;
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          out_ch.valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.data = res;

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> state == S_IDLE) else $error("ready outside idle");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    scount <= nsize) else $error("count above size");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready) else $error("input taken while result waits");
  a_widx: assert property (@(posedge clk) disable iff (rst)
    32'(widx) < 32'(nsize)) else $error("write index out of range");
endmodule
`default_nettype wire

// ===== verif/tfc_checker.sv =====
`default_nettype none
module tfc_checker
  import tfc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic                  in_ready,
  input  wire in_item_t              in_data,
  input  wire logic                  out_valid,
  input  wire logic                  out_ready,
  input  wire out_item_t             out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         errors,
  output int                         pending
);

  longint gain_xx, gain_xy, off_x, gain_yx, gain_yy, off_y, divisor;
  int unsigned n_taps;
  logic signed [15:0] hist_x [MAX_FILTER_DEF];
  logic signed [15:0] hist_y [MAX_FILTER_DEF];
  int unsigned wr_ptr, fill;
  longint prev_x, prev_y;
  out_item_t pointer_q[$];

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint floor_quot(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q--;
    return q;
  endfunction

  function automatic longint map_coord(longint g0, longint g1, longint off,
                                       longint x, longint y);
    longint q;
    if (divisor == 0) return 0;
    q = (g0 * x + g1 * y + off) / divisor;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q;
  endfunction

  // advance the filter state by one sample and build the resulting event
  function automatic out_item_t filter_sample(in_item_t it);
    out_item_t r;
    longint sx, sy, d, maxd, sumx, sumy, ax, ay;
    int drop;
    int unsigned cnt;
    r = '0;
    if (it.buttons == 0) begin
      if (fill >= n_taps) begin
        sx = map_coord(gain_xx, gain_xy, off_x, it.raw_x, it.raw_y);
        sy = map_coord(gain_yx, gain_yy, off_y, it.raw_x, it.raw_y);
        prev_x = sx;
        prev_y = sy;
        r.event_valid = 1'b1;
        r.screen_x = sx[15:0];
        r.screen_y = sy[15:0];
      end
      wr_ptr = 0;
      fill = 0;
      r.accepted = 1'b1;
    end else begin
      hist_x[wr_ptr] = it.raw_x;
      hist_y[wr_ptr] = it.raw_y;
      if (fill < n_taps) fill++;
      if (fill >= n_taps) begin
        drop = -1;
        maxd = 0;
        sumx = 0;
        sumy = 0;
        cnt = 0;
        ax = 0;
        ay = 0;
        if (n_taps > 2) begin
          for (int i = 0; i < n_taps; i++) begin
            d = mag(prev_x - hist_x[i]) + mag(prev_y - hist_y[i]);
            if (d > maxd) begin
              maxd = d;
              drop = i;
            end
          end
        end
        for (int i = 0; i < n_taps; i++) begin
          if (i != drop) begin
            sumx += hist_x[i];
            sumy += hist_y[i];
            cnt++;
          end
        end
        if (cnt != 0) begin
          ax = floor_quot(2 * sumx + cnt, 2 * longint'(cnt));
          ay = floor_quot(2 * sumy + cnt, 2 * longint'(cnt));
        end
        sx = map_coord(gain_xx, gain_xy, off_x, ax, ay);
        sy = map_coord(gain_yx, gain_yy, off_y, ax, ay);
        prev_x = sx;
        prev_y = sy;
        r.event_valid = 1'b1;
        r.screen_x = sx[15:0];
        r.screen_y = sy[15:0];
        r.event_buttons = it.buttons;
        r.accepted = 1'b1;
      end
      wr_ptr = (wr_ptr + 1 >= n_taps) ? 0 : wr_ptr + 1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    logic [4:0] sz;
    if (rst) begin
      gain_xx = 1; gain_xy = 0; off_x = 0;
      gain_yx = 0; gain_yy = 1; off_y = 0;
      divisor = 1;
      n_taps = 5;
      wr_ptr = 0;
      fill = 0;
      prev_x = 0;
      prev_y = 0;
      pointer_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_XX:   gain_xx = longint'($signed(cfg_data));
          REG_XY:   gain_xy = longint'($signed(cfg_data));
          REG_XOFF: off_x   = longint'($signed(cfg_data));
          REG_YX:   gain_yx = longint'($signed(cfg_data));
          REG_YY:   gain_yy = longint'($signed(cfg_data));
          REG_YOFF: off_y   = longint'($signed(cfg_data));
          REG_DIV:  divisor = longint'($signed(cfg_data[17:0]));
          REG_SIZE: begin
            sz = cfg_data[4:0];
            n_taps = (sz == 0) ? 1 : (sz > MAX_FILTER_DEF) ? MAX_FILTER_DEF : sz;
            fill = 0;
            wr_ptr = 0;
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) pointer_q.push_back(filter_sample(in_data));
      if (out_valid && out_ready) begin
        if (pointer_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected event %p", $time, out_data);
        end else begin
          want = pointer_q.pop_front();
          if (want.event_valid !== out_data.event_valid ||
              want.screen_x !== out_data.screen_x ||
              want.screen_y !== out_data.screen_y ||
              want.event_buttons !== out_data.event_buttons ||
              want.accepted !== out_data.accepted) begin
            errors++;
            $display("%0t: mismatch expected %p actual %p", $time, want, out_data);
          end
        end
      end
    end
    pending = pointer_q.size();
  end

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`default_nettype none
module tb_top;
  import tfc_pkg::*;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int errors, pending;
  int items_sent = 0;
  int burst_left = 0;
  int unsigned taps = 5;
  logic hold_off = 1'b0;

  tfc_stream_if #(.T(in_item_t))  in_ch ();
  tfc_stream_if #(.T(out_item_t)) out_ch ();

  touch_filter_and_calibrate dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tfc_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always #6 clk = ~clk;

  // Receiver: rotate through three stall patterns; a long hold-off
  // overrides it so the block backs up and drops its input ready.
  always @(posedge clk) begin
    int unsigned pat;
    pat = 32'((($time / 12) / 64) % 3);
    if (hold_off)
      out_ch.ready <= 1'b0;
    else if (pat == 0)
      out_ch.ready <= 1'b1;
    else if (pat == 1)
      out_ch.ready <= 1'($urandom_range(0, 1));
    else
      out_ch.ready <= ($urandom_range(0, 3) == 0);
  end

  // Long hold-off, counted here in cycles, while the sender keeps offering.
  initial begin
    wait (items_sent >= 300);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (2000) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Hand one sample to the block: start a new burst after a random gap,
  // then hold valid until the transfer happens.
  task automatic push_sample(logic signed [15:0] x, logic signed [15:0] y,
                             logic [4:0] btn);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data <= '{raw_x: x, raw_y: y, buttons: btn};
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    items_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // Load a whole calibration; only done with the block drained.
  task automatic load_calibration(int xx, int xy, int xo, int yx, int yy, int yo,
                                  int div, int unsigned size);
    wait_drained();
    write_reg(REG_XX, xx);
    write_reg(REG_XY, xy);
    write_reg(REG_XOFF, xo);
    write_reg(REG_YX, yx);
    write_reg(REG_YY, yy);
    write_reg(REG_YOFF, yo);
    write_reg(REG_DIV, div);
    write_reg(REG_SIZE, size);
    cfg_we <= 1'b0;
    taps = (size == 0) ? 1 : (size > MAX_FILTER_DEF) ? MAX_FILTER_DEF : size;
  endtask

  function automatic logic [4:0] any_button();
    return 5'($urandom_range(1, 31));
  endfunction

  // Press, hold around one spot with jitter and rare outliers, then release.
  task automatic stroke(int len);
    logic signed [15:0] bx, by, jx, jy;
    int jit;
    bx = 16'($urandom);
    by = 16'($urandom);
    jit = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(0, 40);
    for (int i = 0; i < len; i++) begin
      jx = 16'($urandom_range(0, 2 * jit) - jit);
      jy = 16'($urandom_range(0, 2 * jit) - jit);
      if ($urandom_range(0, 9) == 0) begin
        push_sample(16'($urandom), 16'($urandom), any_button());
      end else begin
        push_sample(bx + jx, by + jy, any_button());
      end
    end
    push_sample(16'($urandom), 16'($urandom), 5'd0);
  endtask

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16;
    if (r == 1) return 0;
    if (r == 2) return $urandom_range(17, 31);
    return $urandom_range(1, 6);
  endfunction

  initial begin
    int mode, sz, dv;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset calibration and five taps: release with an empty ring,
    // all-zero distances so nothing is dropped, coordinate extremes, a tie
    // on the largest distance, then release after a full ring.
    push_sample(16'sd0, 16'sd0, 5'd0);
    repeat (5) push_sample(16'sd0, 16'sd0, 5'd1);
    push_sample(16'sh7fff, -16'sh8000, 5'd31);
    push_sample(-16'sh8000, 16'sh7fff, 5'd16);
    push_sample(16'sd10, 16'sd10, 5'd2);
    push_sample(-16'sd10, -16'sd10, 5'd4);
    push_sample(16'sd3, -16'sd3, 5'd8);
    push_sample(-16'sh8000, -16'sh8000, 5'd0);
    push_sample(16'sh7fff, 16'sh7fff, 5'd1);

    // Extreme gains and a single tap, then small gains and two taps; divisor 65536, then -65536.
    load_calibration(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                     32'h7fffffff, 32'h80000000, 65536, 1);
    push_sample(16'sh7fff, 16'sh7fff, 5'd3);
    push_sample(-16'sh8000, 16'sh7fff, 5'd3);
    push_sample(16'sd1, -16'sd1, 5'd0);
    load_calibration(-7, 3, 5, 2, -9, -1, -65536, 2);
    push_sample(16'sh7fff, 16'sh7fff, 5'd5);
    push_sample(-16'sh8000, -16'sh8000, 5'd5);
    push_sample(16'sd7, -16'sd8, 5'd0);
    // Zero divisor maps everything to the origin.
    load_calibration(1000, 1000, 1000, 1000, 1000, 1000, 0, 3);
    repeat (3) push_sample(16'sd100, -16'sd100, 5'd9);
    push_sample(16'sd5, 16'sd5, 5'd0);

    while (items_sent < 1220) begin
      mode = $urandom_range(0, 3);
      sz = pick_size();
      dv = int'($signed(18'($urandom)));
      case (mode)
        0: load_calibration($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
                            $urandom_range(0, 200) - 100, $urandom_range(0, 8) - 4,
                            $urandom_range(0, 8) - 4, $urandom_range(0, 200) - 100,
                            $urandom_range(0, 1) ? 1 : -$urandom_range(1, 3), sz);
        1: load_calibration($urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, dv, sz);
        2: load_calibration(65536 + $urandom_range(0, 4000) - 2000,
                            $urandom_range(0, 2000) - 1000, $urandom,
                            $urandom_range(0, 2000) - 1000,
                            65536 + $urandom_range(0, 4000) - 2000, $urandom,
                            $urandom_range(60000, 65536), sz);
        default: load_calibration(1, 0, 0, 0, 1, 0, $urandom_range(0, 1) ? 1 : 0, sz);
      endcase
      repeat (25) begin
        if (items_sent < 1220) begin
          if ($urandom_range(0, 7) == 0) begin
            // noise: stray release or stray press
            push_sample(16'($urandom), 16'($urandom),
                        $urandom_range(0, 1) ? 5'd0 : any_button());
          end else begin
            stroke($urandom_range(0, 2 * taps + 3));
          end
        end
      end
    end

    wait_drained();
    repeat (400) @(posedge clk);
    if (errors == 0)
      $display("[touch_filter_and_calibrate] OK");
    else
      $display("[touch_filter_and_calibrate] ERROR");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #40000000;
    $display("[touch_filter_and_calibrate] ERROR");
    $finish;
  end

endmodule
`default_nettype wire
